[rtl/pfa_pkg.sv]
// pfa_pkg: shared types and codes for the partition fit allocator
// used by pfa_ctrl, pfa_dp and partition_fit_allocator; no dependencies
package pfa_pkg;

    localparam int CMD_W     = 2;
    localparam int BIDX_W    = 5;
    localparam int PSIZE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int BCNT_W    = 6;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEST  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WORST = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd2;

    localparam logic [BCNT_W-1:0] BCNT_RESET = 6'd1;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic scan_rd;
        logic used_rd;
        logic commit;
    } pfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lim_zero;
        logic scan_last;
        logic out_free;
    } pfa_sts_t;

endpackage

[rtl/partition_fit_allocator.sv]
// partition_fit_allocator: fixed-partition allocator, first/best/worst fit
// depends on pfa_pkg, pfa_ctrl (sequencer) and pfa_dp (table and datapath)
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  s_       | in        | s_tvalid / s_tready    | tuser: cmd; tdata: block_index, size
//  m_       | out       | m_tvalid / m_tready    | tuser: status; tdata: chosen_block,
//           |           |                        |        free_left, used_total
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_data: block_count
//
// load: accept, then commit
// allocate: accept, one table read per scanned entry, compare, used read, commit;
//   block_count capped at MAX_BLOCKS entries scanned; block_count 0 scans nothing
//   and goes from accept straight to commit; the single table read port sets
//   the pace of the scan
// reset: aresetn low clears control and the used-size valid bits; block_count = 1
// a finished result waits in the output register; a stalled m_ side holds only
//   the commit of the next request, not its acceptance or scan
module partition_fit_allocator #(
    parameter int MAX_BLOCKS = 32,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfa_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
    input  logic [pfa_pkg::S_TDATA_W-1:0] s_tdata,   // [4:0] block_index, [20:5] size
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfa_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic [pfa_pkg::M_TDATA_W-1:0] m_tdata,   // [4:0] chosen_block,
                                                     // [20:5] free_left, [36:21] used_total
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::BCNT_W-1:0]    cfg_data
);

    pfa_pkg::pfa_cmd_t cmd;
    pfa_pkg::pfa_sts_t sts;
    logic              is_load;

    assign cfg_ready = 1'b1;
    assign is_load   = (s_tuser == pfa_pkg::CMD_LOAD);

    pfa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_is_load (is_load),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    pfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/pfa_ctrl.sv]
// pfa_ctrl: sequencer for load and allocate requests
// depends on pfa_pkg; drives pfa_dp through pfa_cmd_t and reads pfa_sts_t
module pfa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_is_load,
    output logic             in_ready,
    input  pfa_pkg::pfa_sts_t sts,
    output pfa_pkg::pfa_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FIN    = 3'd2;
    localparam logic [2:0] S_RDU    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    // zero block count or load: straight to the result
                    if (in_is_load || sts.lim_zero) begin
                        state_next = S_COMMIT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                // last compare lands this cycle
                state_next = S_RDU;
            end
            S_RDU: begin
                cmd.used_rd = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a request is in flight");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.latch_in, cmd.scan_rd, cmd.used_rd, cmd.commit}))
        else $error("more than one datapath command at once");

    a_no_empty_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !sts.lim_zero)
        else $error("scan running over an empty table");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && sts.scan_last) |=> (state_reg == S_FIN))
        else $error("scan did not stop at the last entry");

endmodule

[rtl/pfa_dp.sv]
// pfa_dp: partition table memories, scan compare, write-back and result register
// depends on pfa_pkg; sequenced by pfa_ctrl
module pfa_dp #(
    parameter int MAX_BLOCKS = 32,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  pfa_pkg::pfa_cmd_t                cmd,
    output pfa_pkg::pfa_sts_t                sts,
    input  logic [pfa_pkg::CMD_W-1:0]        s_tuser,
    input  logic [pfa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             cfg_valid,
    input  logic [pfa_pkg::BCNT_W-1:0]       cfg_data,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [pfa_pkg::STATUS_W-1:0]     m_tuser,
    output logic [pfa_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [pfa_pkg::BCNT_W-1:0]   bcnt_reg;
    logic [pfa_pkg::CMD_W-1:0]    cmd_reg;
    logic [pfa_pkg::BIDX_W-1:0]   idx_reg;
    logic [SIZE_WIDTH-1:0]        sz_reg;
    logic [CNT_W-1:0]             scan_reg;
    logic                         rd_vld_reg;
    logic [IDX_W-1:0]             rd_addr_reg;
    logic [SIZE_WIDTH-1:0]        free_rd_reg;
    logic [SIZE_WIDTH-1:0]        best_reg;
    logic [IDX_W-1:0]             pick_reg;
    logic                         found_reg;
    logic [SIZE_WIDTH-1:0]        used_rd_reg;
    logic                         used_hit_reg;
    logic [MAX_BLOCKS-1:0]        used_vld_reg;
    logic                         m_tvalid_reg;
    logic [pfa_pkg::STATUS_W-1:0] m_tuser_reg;
    logic [pfa_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [SIZE_WIDTH-1:0] free_mem [MAX_BLOCKS];
    logic [SIZE_WIDTH-1:0] used_mem [MAX_BLOCKS];

    logic [CNT_W-1:0]       lim;
    logic                   ge;
    logic                   take;
    logic                   ld;
    logic                   idx_ok;
    logic                   fit;
    logic [SIZE_WIDTH-1:0]  used_cur;
    logic [SIZE_WIDTH:0]    used_sum;
    logic [SIZE_WIDTH-1:0]  used_new;
    logic [SIZE_WIDTH-1:0]  free_new;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [SIZE_WIDTH-1:0]  wr_free;
    logic [SIZE_WIDTH-1:0]  wr_used;
    logic [pfa_pkg::STATUS_W-1:0] res_status;
    logic [pfa_pkg::BIDX_W-1:0]   res_block;
    logic [pfa_pkg::PSIZE_W-1:0]  res_free;
    logic [pfa_pkg::PSIZE_W-1:0]  res_used;

    // block count saturates at the table depth
    assign lim = (32'(bcnt_reg) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bcnt_reg);

    assign sts.lim_zero  = (lim == '0);
    assign sts.scan_last = (scan_reg == lim - CNT_W'(1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bcnt_reg <= pfa_pkg::BCNT_RESET;
        end else if (cfg_valid) begin
            bcnt_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[pfa_pkg::BIDX_W-1:0];
            sz_reg  <= SIZE_WIDTH'(s_tdata[pfa_pkg::BIDX_W +: pfa_pkg::PSIZE_W]);
        end
    end

    // scan: one table read per cycle, compared in the cycle after the read
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            scan_reg <= '0;
        end else if (cmd.scan_rd) begin
            scan_reg <= scan_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            free_rd_reg <= free_mem[IDX_W'(scan_reg)];
            rd_addr_reg <= IDX_W'(scan_reg);
        end
        if (wr_en) begin
            free_mem[wr_addr] <= wr_free;
        end
    end

    assign ge = (free_rd_reg >= sz_reg);

    always_comb begin
        case (cmd_reg)
            pfa_pkg::CMD_FIRST: take = ge && !found_reg;
            pfa_pkg::CMD_BEST:  take = ge && (!found_reg || free_rd_reg < best_reg);
            pfa_pkg::CMD_WORST: take = !found_reg || free_rd_reg >= best_reg;
            default:            take = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.latch_in) begin
            found_reg <= 1'b0;
        end else if (rd_vld_reg && take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && take) begin
            best_reg <= free_rd_reg;
            pick_reg <= rd_addr_reg;
        end
    end

    // used sizes: entries never loaded read as zero
    always_ff @(posedge aclk) begin
        if (cmd.used_rd) begin
            used_rd_reg  <= used_mem[pick_reg];
            used_hit_reg <= used_vld_reg[pick_reg];
        end
        if (wr_en) begin
            used_mem[wr_addr] <= wr_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_vld_reg <= '0;
        end else if (wr_en) begin
            used_vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign ld       = (cmd_reg == pfa_pkg::CMD_LOAD);
    assign idx_ok   = (32'(idx_reg) < 32'(MAX_BLOCKS));
    assign fit      = found_reg && (best_reg >= sz_reg);
    assign used_cur = used_hit_reg ? used_rd_reg : '0;
    assign used_sum = {1'b0, used_cur} + {1'b0, sz_reg};
    assign used_new = used_sum[SIZE_WIDTH] ? '1 : used_sum[SIZE_WIDTH-1:0];
    assign free_new = best_reg - sz_reg;

    assign wr_en   = cmd.commit && (ld ? idx_ok : fit);
    assign wr_addr = ld ? IDX_W'(idx_reg) : pick_reg;
    assign wr_free = ld ? sz_reg : free_new;
    assign wr_used = ld ? '0 : used_new;

    always_comb begin
        if (ld) begin
            res_status = pfa_pkg::ST_LOADED;
            res_block  = idx_reg;
            res_free   = idx_ok ? pfa_pkg::PSIZE_W'(sz_reg) : '0;
            res_used   = '0;
        end else if (fit) begin
            res_status = pfa_pkg::ST_ALLOC;
            res_block  = pfa_pkg::BIDX_W'(pick_reg);
            res_free   = pfa_pkg::PSIZE_W'(free_new);
            res_used   = pfa_pkg::PSIZE_W'(used_new);
        end else begin
            res_status = pfa_pkg::ST_NOFIT;
            res_block  = '0;
            res_free   = '0;
            res_used   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {3'b000, res_used, res_free, res_block};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result overwrote a beat not yet taken");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_alloc_no_overdraw: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !ld && fit) |-> (free_new <= best_reg))
        else $error("allocation grew the free size");

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for partition_fit_allocator (load, first/best/worst fit)
// depends on pfa_pkg and the partition_fit_allocator rtl; tracks the partition table itself
// directed corner cases first, then random request mixes under several block counts
module testbench;
    import pfa_pkg::*;

    localparam int TBL_DEPTH = 32;
    localparam int SETTLE    = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIDX_W-1:0]   blk;
        logic [PSIZE_W-1:0]  free_left;
        logic [PSIZE_W-1:0]  used_total;
    } grant_t;

    class partition_scoreboard;
        logic [PSIZE_W-1:0] free_tbl [TBL_DEPTH];
        logic [PSIZE_W-1:0] used_tbl [TBL_DEPTH];
        int unsigned        scan_len;
        grant_t             pending_grants [$];
        int                 errors;
        int                 n_loads;
        int                 n_grants;
        int                 n_nofit;

        function new();
            scan_len = 32'(BCNT_RESET);
            foreach (free_tbl[i]) begin
                free_tbl[i] = '0;
                used_tbl[i] = '0;
            end
            errors   = 0;
            n_loads  = 0;
            n_grants = 0;
            n_nofit  = 0;
        endfunction

        function void set_block_count(logic [BCNT_W-1:0] cnt);
            scan_len = (32'(cnt) > TBL_DEPTH) ? TBL_DEPTH : 32'(cnt);
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                                   logic [PSIZE_W-1:0] sz);
            grant_t          g;
            int              pick;
            int              i;
            bit              found;
            logic [PSIZE_W:0] sum;
            g = '0;
            if (cmd == CMD_LOAD) begin
                free_tbl[idx] = sz;
                used_tbl[idx] = '0;
                g.status      = ST_LOADED;
                g.blk         = idx;
                g.free_left   = sz;
                n_loads++;
            end else begin
                found = 0;
                pick  = 0;
                for (i = 0; i < scan_len; i++) begin
                    case (cmd)
                        CMD_FIRST: begin
                            if (!found && free_tbl[i] >= sz) begin
                                pick  = i;
                                found = 1;
                            end
                        end
                        CMD_BEST: begin
                            if (free_tbl[i] >= sz && (!found || free_tbl[i] < free_tbl[pick])) begin
                                pick  = i;
                                found = 1;
                            end
                        end
                        default: begin
                            // worst fit: ties go to the higher index
                            if (!found || free_tbl[i] >= free_tbl[pick]) begin
                                pick  = i;
                                found = 1;
                            end
                        end
                    endcase
                end
                if (found && free_tbl[pick] >= sz) begin
                    free_tbl[pick] = free_tbl[pick] - sz;
                    sum            = {1'b0, used_tbl[pick]} + {1'b0, sz};
                    used_tbl[pick] = sum[PSIZE_W] ? '1 : sum[PSIZE_W-1:0];
                    g.status       = ST_ALLOC;
                    g.blk          = pick[BIDX_W-1:0];
                    g.free_left    = free_tbl[pick];
                    g.used_total   = used_tbl[pick];
                    n_grants++;
                end else begin
                    g.status = ST_NOFIT;
                    n_nofit++;
                end
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic [STATUS_W-1:0] st, logic [M_TDATA_W-1:0] data);
            grant_t want;
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: status %0d data %h",
                         $time, st, data);
                return;
            end
            want = pending_grants.pop_front();
            if (st != want.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, st);
            end
            if (data[4:0] != want.blk) begin
                errors++;
                $display("%0t: chosen_block expected %0d got %0d", $time, want.blk, data[4:0]);
            end
            if (data[20:5] != want.free_left) begin
                errors++;
                $display("%0t: free_left expected %0d got %0d",
                         $time, want.free_left, data[20:5]);
            end
            if (data[36:21] != want.used_total) begin
                errors++;
                $display("%0t: used_total expected %0d got %0d",
                         $time, want.used_total, data[36:21]);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [CMD_W-1:0]      s_tuser;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [STATUS_W-1:0]   m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BCNT_W-1:0]     cfg_data;

    partition_scoreboard   sb;
    bit                    no_gaps;

    partition_fit_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin : stall_gen
        int hold;
        if (!aresetn) begin
            hold = 0;
            m_tready <= 1'b0;
        end else if (hold > 0) begin
            m_tready <= 1'b0;
            hold--;
        end else begin
            m_tready <= 1'b1;
            hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_grant(m_tuser, m_tdata);
    end

    // called and returns at a falling edge
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                                logic [PSIZE_W-1:0] sz);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, sz, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, idx, sz);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_block_count(logic [BCNT_W-1:0] cnt);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cnt;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_block_count(cnt);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PSIZE_W-1:0] pick_load_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        else if (roll < 40)
            // a few shared sizes so best and worst fit see ties
            return 16'd256 << $urandom_range(0, 2);
        else if (roll < 70)
            return PSIZE_W'($urandom_range(0, 65535));
        else
            return PSIZE_W'($urandom_range(0, 2000));
    endfunction

    function automatic logic [PSIZE_W-1:0] pick_alloc_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        else if (roll < 20)
            return '1;
        else if (roll < 30)
            return PSIZE_W'($urandom_range(0, 65535));
        else
            return PSIZE_W'($urandom_range(1, 600));
    endfunction

    task automatic random_request();
        logic [CMD_W-1:0] cmd;
        if ($urandom_range(0, 99) < 25) begin
            send_request(CMD_LOAD, BIDX_W'($urandom_range(0, TBL_DEPTH - 1)),
                         pick_load_size());
        end else begin
            case ($urandom_range(1, 3))
                1:       cmd = CMD_FIRST;
                2:       cmd = CMD_BEST;
                default: cmd = CMD_WORST;
            endcase
            send_request(cmd, BIDX_W'($urandom_range(0, TBL_DEPTH - 1)), pick_alloc_size());
        end
    endtask

    initial begin
        logic [BCNT_W-1:0] phase_counts [6];
        int                p;
        int                k;
        sb        = new();
        no_gaps   = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // single partition at the reset block count
        send_request(CMD_LOAD,  5'd0, 16'd300);
        send_request(CMD_FIRST, 5'd0, 16'd100);
        send_request(CMD_WORST, 5'd9, 16'd201);
        send_request(CMD_BEST,  5'd0, 16'd200);

        // loads past the block count, extreme and tied sizes
        send_request(CMD_LOAD, 5'd0, 16'd300);
        send_request(CMD_LOAD, 5'd1, 16'hFFFF);
        send_request(CMD_LOAD, 5'd2, 16'd500);
        send_request(CMD_LOAD, 5'd3, 16'd300);
        send_request(CMD_LOAD, 5'd4, 16'd0);
        send_request(CMD_LOAD, 5'd5, 16'hFFFF);
        send_request(CMD_LOAD, 5'd6, 16'd1000);
        send_request(CMD_LOAD, 5'd7, 16'd500);

        write_block_count(6'd8);
        send_request(CMD_FIRST, 5'd31, 16'd400);
        send_request(CMD_BEST,  5'd0,  16'd400);
        send_request(CMD_WORST, 5'd0,  16'd1);
        send_request(CMD_BEST,  5'd0,  16'hFFFF);
        send_request(CMD_WORST, 5'd0,  16'hFFFF);
        send_request(CMD_FIRST, 5'd0,  16'd0);
        send_request(CMD_BEST,  5'd0,  16'd0);

        // nothing scanned
        write_block_count(6'd0);
        send_request(CMD_FIRST, 5'd0, 16'd5);
        send_request(CMD_BEST,  5'd0, 16'd0);
        send_request(CMD_WORST, 5'd0, 16'd0);

        // fill the whole table before any wider scan
        for (k = 0; k < TBL_DEPTH; k++)
            send_request(CMD_LOAD, k[BIDX_W-1:0], pick_load_size());

        phase_counts[0] = 6'd63;
        phase_counts[1] = 6'd32;
        phase_counts[2] = 6'd1;
        phase_counts[3] = 6'd0;
        phase_counts[4] = BCNT_W'($urandom_range(2, 31));
        phase_counts[5] = 6'd32;
        for (p = 0; p < 6; p++) begin
            write_block_count(phase_counts[p]);
            no_gaps = (p == 1);
            for (k = 0; k < 232; k++)
                random_request();
        end
        no_gaps = 0;
        drain();

        $display("%0d beats: %0d loads, %0d grants, %0d no-fit", sb.n_loads + sb.n_grants +
                 sb.n_nofit, sb.n_loads, sb.n_grants, sb.n_nofit);
        $display("block counts 0, 1, 8, 32, 63 and one random value; all three fit policies");
        if (sb.errors == 0 && sb.pending_grants.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
